[hw/rtl/npps_pkg.sv]
`timescale 1ns / 1ps

package npps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int TAG_W   = 16;
  localparam int BURST_W = 16;
  localparam int ARR_W   = 16;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 21;
  localparam int SUM_W   = 25;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_TURN,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } npps_state_t;

  // one stored job descriptor
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arr;
    logic [PRIO_W-1:0]  prio;
  } npps_job_t;

  // candidate presented to the comparator
  typedef struct packed {
    logic               vld;
    logic               done;
    logic [IDX_W-1:0]   idx;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arr;
    logic [PRIO_W-1:0]  prio;
  } npps_cand_t;

  // outcome of one scan pass
  typedef struct packed {
    logic               pick_vld;
    logic [IDX_W-1:0]   pick_idx;
    logic [BURST_W-1:0] pick_burst;
    logic [ARR_W-1:0]   pick_arr;
    logic               next_vld;
    logic [ARR_W-1:0]   next_arr;
  } npps_scan_res_t;

endpackage

[hw/rtl/npps_job_store.sv]
`timescale 1ns / 1ps

module npps_job_store (
  input  logic                               clk,
  input  logic                               load_we,
  input  logic [npps_pkg::IDX_W-1:0]         load_addr,
  input  npps_pkg::npps_job_t                load_data,
  input  logic                               fin_we,
  input  logic [npps_pkg::IDX_W-1:0]         fin_addr,
  input  logic [npps_pkg::TIME_W-1:0]        fin_data,
  input  logic [npps_pkg::IDX_W-1:0]         rd_addr,
  output npps_pkg::npps_job_t                rd_job,
  output logic [npps_pkg::TIME_W-1:0]        rd_finish
);

  npps_pkg::npps_job_t          job_mem [npps_pkg::MAX_PROCS];
  logic [npps_pkg::TIME_W-1:0]  fin_mem [npps_pkg::MAX_PROCS];

  always_ff @(posedge clk) begin
    if (load_we) begin
      job_mem[load_addr] <= load_data;
    end
    if (fin_we) begin
      fin_mem[fin_addr] <= fin_data;
    end
    rd_job    <= job_mem[rd_addr];
    rd_finish <= fin_mem[rd_addr];
  end

endmodule

[hw/rtl/npps_scan.sv]
`timescale 1ns / 1ps

module npps_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  npps_pkg::npps_cand_t         cand,
  input  logic [npps_pkg::TIME_W-1:0]  sim_time,
  output npps_pkg::npps_scan_res_t     res
);

  logic                           pick_vld_r, pick_vld_nxt;
  logic [npps_pkg::IDX_W-1:0]     pick_idx_r, pick_idx_nxt;
  logic [npps_pkg::PRIO_W-1:0]    pick_prio_r, pick_prio_nxt;
  logic [npps_pkg::BURST_W-1:0]   pick_burst_r, pick_burst_nxt;
  logic [npps_pkg::ARR_W-1:0]     pick_arr_r, pick_arr_nxt;
  logic                           next_vld_r, next_vld_nxt;
  logic [npps_pkg::ARR_W-1:0]     next_arr_r, next_arr_nxt;
  logic                           arrived;

  assign arrived = ({{(npps_pkg::TIME_W - npps_pkg::ARR_W){1'b0}}, cand.arr} <= sim_time);

  always_comb begin
    pick_vld_nxt   = pick_vld_r;
    pick_idx_nxt   = pick_idx_r;
    pick_prio_nxt  = pick_prio_r;
    pick_burst_nxt = pick_burst_r;
    pick_arr_nxt   = pick_arr_r;
    next_vld_nxt   = next_vld_r;
    next_arr_nxt   = next_arr_r;
    if (clr) begin
      pick_vld_nxt = 1'b0;
      next_vld_nxt = 1'b0;
    end else if (cand.vld && !cand.done) begin
      if (arrived) begin
        // strict less-than keeps the lower index on a tie
        if (!pick_vld_r || (cand.prio < pick_prio_r)) begin
          pick_vld_nxt   = 1'b1;
          pick_idx_nxt   = cand.idx;
          pick_prio_nxt  = cand.prio;
          pick_burst_nxt = cand.burst;
          pick_arr_nxt   = cand.arr;
        end
      end else if (!next_vld_r || (cand.arr < next_arr_r)) begin
        next_vld_nxt = 1'b1;
        next_arr_nxt = cand.arr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pick_vld_r <= 1'b0;
      next_vld_r <= 1'b0;
    end else begin
      pick_vld_r <= pick_vld_nxt;
      next_vld_r <= next_vld_nxt;
    end
    pick_idx_r   <= pick_idx_nxt;
    pick_prio_r  <= pick_prio_nxt;
    pick_burst_r <= pick_burst_nxt;
    pick_arr_r   <= pick_arr_nxt;
    next_arr_r   <= next_arr_nxt;
  end

  assign res.pick_vld   = pick_vld_r;
  assign res.pick_idx   = pick_idx_r;
  assign res.pick_burst = pick_burst_r;
  assign res.pick_arr   = pick_arr_r;
  assign res.next_vld   = next_vld_r;
  assign res.next_arr   = next_arr_r;

endmodule

[hw/rtl/nonpreemptive_priority_scheduler.sv]
`timescale 1ns / 1ps
// Load: one descriptor transaction per cycle while idle, no result.
// Schedule (after the final descriptor): each decision is one comparator pass over
// the n stored jobs, then the DECIDE and TURN update states; an idle gap costs a pass and DECIDE.
// Results: each passes through OUT_RD, OUT_LD and OUT_HOLD (held until out_ready), in load order.
// Reset (rst_n low, synchronous) clears the FSM, job count, done flags, time and totals.

module nonpreemptive_priority_scheduler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [npps_pkg::TAG_W-1:0]          in_job_tag,
  input  logic [npps_pkg::BURST_W-1:0]        in_run_length,
  input  logic [npps_pkg::ARR_W-1:0]          in_arrival_tick,
  input  logic [npps_pkg::PRIO_W-1:0]         in_urgency,
  input  logic                                in_final_job,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [npps_pkg::TAG_W-1:0]          out_tag,
  output logic [npps_pkg::TIME_W-1:0]         out_finish_tick,
  output logic [npps_pkg::TIME_W-1:0]         out_wait_ticks,
  output logic [npps_pkg::TIME_W-1:0]         out_turnaround_ticks,
  output logic [npps_pkg::SUM_W-1:0]          out_sum_wait,
  output logic [npps_pkg::SUM_W-1:0]          out_sum_turnaround,
  output logic                                out_last_result
);

  localparam int IDX_W  = npps_pkg::IDX_W;
  localparam int CNT_W  = npps_pkg::CNT_W;
  localparam int TIME_W = npps_pkg::TIME_W;
  localparam int SUM_W  = npps_pkg::SUM_W;
  localparam int NPROC  = npps_pkg::MAX_PROCS;

  npps_pkg::npps_state_t state_r, state_nxt;

  // set bookkeeping
  logic [CNT_W-1:0]   count_r, count_nxt;      // jobs stored
  logic [CNT_W-1:0]   left_r, left_nxt;        // jobs not yet finished
  logic [NPROC-1:0]   done_r, done_nxt;
  logic [TIME_W-1:0]  sim_r, sim_nxt;
  logic [SUM_W-1:0]   wait_tot_r, wait_tot_nxt;
  logic [SUM_W-1:0]   turn_tot_r, turn_tot_nxt;

  // scan sequencer: issue address, then compare in the next cycle
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0]   out_idx_r, out_idx_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [npps_pkg::TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic [TIME_W-1:0]  out_fin_r, out_fin_nxt;
  logic [TIME_W-1:0]  out_wait_r, out_wait_nxt;
  logic [TIME_W-1:0]  out_turn_r, out_turn_nxt;
  logic [SUM_W-1:0]   out_sumw_r, out_sumw_nxt;
  logic [SUM_W-1:0]   out_sumt_r, out_sumt_nxt;
  logic               out_last_r, out_last_nxt;

  // store and comparator hookup
  logic                       load_we;
  npps_pkg::npps_job_t        load_data;
  logic                       fin_we;
  logic [IDX_W-1:0]           rd_addr;
  npps_pkg::npps_job_t        rd_job;
  logic [TIME_W-1:0]          rd_finish;
  logic                       scan_clr;
  npps_pkg::npps_cand_t       cand;
  npps_pkg::npps_scan_res_t   scan_res;

  logic [TIME_W-1:0]          ta_calc;
  logic                       out_is_last;

  assign load_data.tag   = in_job_tag;
  assign load_data.burst = in_run_length;
  assign load_data.arr   = in_arrival_tick;
  assign load_data.prio  = in_urgency;

  npps_job_store u_store (
    .clk       (clk),
    .load_we   (load_we),
    .load_addr (count_r[IDX_W-1:0]),
    .load_data (load_data),
    .fin_we    (fin_we),
    .fin_addr  (scan_res.pick_idx),
    .fin_data  (sim_r),
    .rd_addr   (rd_addr),
    .rd_job    (rd_job),
    .rd_finish (rd_finish)
  );

  assign cand.vld   = cmp_vld_r;
  assign cand.done  = done_r[cmp_idx_r];
  assign cand.idx   = cmp_idx_r;
  assign cand.burst = rd_job.burst;
  assign cand.arr   = rd_job.arr;
  assign cand.prio  = rd_job.prio;

  npps_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (scan_clr),
    .cand     (cand),
    .sim_time (sim_r),
    .res      (scan_res)
  );

  // turnaround of the entry on the read port
  assign ta_calc     = rd_finish - TIME_W'(rd_job.arr);
  assign out_is_last = ((out_idx_r + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    done_nxt      = done_r;
    sim_nxt       = sim_r;
    wait_tot_nxt  = wait_tot_r;
    turn_tot_nxt  = turn_tot_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    out_idx_nxt   = out_idx_r;
    out_valid_nxt = out_valid_r;
    out_tag_nxt   = out_tag_r;
    out_fin_nxt   = out_fin_r;
    out_wait_nxt  = out_wait_r;
    out_turn_nxt  = out_turn_r;
    out_sumw_nxt  = out_sumw_r;
    out_sumt_nxt  = out_sumt_r;
    out_last_nxt  = out_last_r;
    load_we       = 1'b0;
    fin_we        = 1'b0;
    scan_clr      = 1'b0;
    rd_addr       = issue_r[IDX_W-1:0];
    in_ready      = 1'b0;

    unique case (state_r)
      npps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // a full store drops the descriptor, the final flag still counts
          if (count_r < CNT_W'(NPROC)) begin
            load_we                     = 1'b1;
            done_nxt[count_r[IDX_W-1:0]] = 1'b0;
            count_nxt                   = count_r + CNT_W'(1);
          end
          if (in_final_job) begin
            left_nxt  = count_nxt;
            issue_nxt = '0;
            scan_clr  = 1'b1;
            state_nxt = npps_pkg::ST_SCAN;
          end
        end
      end

      npps_pkg::ST_SCAN: begin
        if (issue_r < count_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt   = issue_r + CNT_W'(1);
        end else if (!cmp_vld_r) begin
          state_nxt = npps_pkg::ST_DECIDE;
        end
      end

      npps_pkg::ST_DECIDE: begin
        if (scan_res.pick_vld) begin
          // waiting time = start - arrival
          sim_nxt      = sim_r + TIME_W'(scan_res.pick_burst);
          wait_tot_nxt = wait_tot_r + SUM_W'(sim_r - TIME_W'(scan_res.pick_arr));
          left_nxt     = left_r - CNT_W'(1);
          state_nxt    = npps_pkg::ST_TURN;
        end else begin
          // nothing arrived: jump to the earliest pending arrival
          sim_nxt   = TIME_W'(scan_res.next_arr);
          issue_nxt = '0;
          scan_clr  = 1'b1;
          state_nxt = npps_pkg::ST_SCAN;
        end
      end

      npps_pkg::ST_TURN: begin
        // sim_r now holds the completion time
        fin_we                      = 1'b1;
        done_nxt[scan_res.pick_idx] = 1'b1;
        turn_tot_nxt = turn_tot_r + SUM_W'(sim_r - TIME_W'(scan_res.pick_arr));
        if (left_r == '0) begin
          out_idx_nxt = '0;
          state_nxt   = npps_pkg::ST_OUT_RD;
        end else begin
          issue_nxt = '0;
          scan_clr  = 1'b1;
          state_nxt = npps_pkg::ST_SCAN;
        end
      end

      npps_pkg::ST_OUT_RD: begin
        rd_addr   = out_idx_r[IDX_W-1:0];
        state_nxt = npps_pkg::ST_OUT_LD;
      end

      npps_pkg::ST_OUT_LD: begin
        out_tag_nxt   = rd_job.tag;
        out_fin_nxt   = rd_finish;
        out_turn_nxt  = ta_calc;
        out_wait_nxt  = ta_calc - TIME_W'(rd_job.burst);
        out_last_nxt  = out_is_last;
        out_sumw_nxt  = out_is_last ? wait_tot_r : '0;
        out_sumt_nxt  = out_is_last ? turn_tot_r : '0;
        out_valid_nxt = 1'b1;
        state_nxt     = npps_pkg::ST_OUT_HOLD;
      end

      npps_pkg::ST_OUT_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            // set complete: back to an empty store
            count_nxt    = '0;
            done_nxt     = '0;
            sim_nxt      = '0;
            wait_tot_nxt = '0;
            turn_tot_nxt = '0;
            state_nxt    = npps_pkg::ST_IDLE;
          end else begin
            out_idx_nxt = out_idx_r + CNT_W'(1);
            state_nxt   = npps_pkg::ST_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = npps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= npps_pkg::ST_IDLE;
      count_r     <= '0;
      left_r      <= '0;
      done_r      <= '0;
      sim_r       <= '0;
      wait_tot_r  <= '0;
      turn_tot_r  <= '0;
      issue_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      done_r      <= done_nxt;
      sim_r       <= sim_nxt;
      wait_tot_r  <= wait_tot_nxt;
      turn_tot_r  <= turn_tot_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_idx_r   <= out_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmp_idx_r  <= cmp_idx_nxt;
    out_tag_r  <= out_tag_nxt;
    out_fin_r  <= out_fin_nxt;
    out_wait_r <= out_wait_nxt;
    out_turn_r <= out_turn_nxt;
    out_sumw_r <= out_sumw_nxt;
    out_sumt_r <= out_sumt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_tag              = out_tag_r;
  assign out_finish_tick      = out_fin_r;
  assign out_wait_ticks       = out_wait_r;
  assign out_turnaround_ticks = out_turn_r;
  assign out_sum_wait         = out_sumw_r;
  assign out_sum_turnaround   = out_sumt_r;
  assign out_last_result      = out_last_r;

endmodule

[hw/rtl/npps_checker.sv]
`timescale 1ns / 1ps

module npps_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [npps_pkg::TAG_W-1:0]          in_job_tag,
  input  logic [npps_pkg::BURST_W-1:0]        in_run_length,
  input  logic [npps_pkg::ARR_W-1:0]          in_arrival_tick,
  input  logic [npps_pkg::PRIO_W-1:0]         in_urgency,
  input  logic                                in_final_job,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [npps_pkg::TAG_W-1:0]          out_tag,
  input  logic [npps_pkg::TIME_W-1:0]         out_finish_tick,
  input  logic [npps_pkg::TIME_W-1:0]         out_wait_ticks,
  input  logic [npps_pkg::TIME_W-1:0]         out_turnaround_ticks,
  input  logic [npps_pkg::SUM_W-1:0]          out_sum_wait,
  input  logic [npps_pkg::SUM_W-1:0]          out_sum_turnaround,
  input  logic                                out_last_result
);

  // loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("in_ready high while a result is pending");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_tag)
      && $stable(out_finish_tick) && $stable(out_last_result)))
    else $error("stalled result changed");

  // wait <= turnaround <= finish
  a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_wait_ticks <= out_turnaround_ticks)
      && (out_turnaround_ticks <= out_finish_tick)))
    else $error("result times out of order");

  // totals only on the final result
  a_totals_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_result) |-> ((out_sum_wait == '0) && (out_sum_turnaround == '0)))
    else $error("totals on a non-final result");

  // after the final transaction the block stops loading
  a_final_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_final_job) |=> !in_ready)
    else $error("ready right after final descriptor");

endmodule

bind nonpreemptive_priority_scheduler npps_checker u_npps_checker (.*);
